// ===== hdl/itra_pkg.sv =====
// Shared types, character codes and digit mapping for the radix text converter.
// No dependencies; the divider, top level, checker and testbench import this package.
package itra_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned RADIX_W = 5;
    localparam int unsigned CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 8'h61;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 5'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    // Status of the serial divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } itra_div_stat_t;

    // Map one digit to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE)
        begin
            c = CHAR_A_LOWER + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== hdl/itra_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module itra_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and read port with output register held between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/itra_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// Depends on itra_pkg.
module itra_div
    import itra_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder,
    output itra_div_stat_t        stat
);

    localparam int unsigned CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RADIX_W-1:0]    trial;
    logic [RADIX_W-1:0]    diff;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try the divisor
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = (trial >= divisor);
    assign diff  = trial - divisor;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

// ===== hdl/integer_to_radix_ascii.sv =====
// Top level of the integer to radix text converter (bases 2 to 16).
// Depends on itra_pkg, itra_div and itra_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  input   | in        | in_valid / in_stall | value (VALUE_BITS, signed)
//  output  | out       | out_valid/out_stall | character (8), final_char (1)
//  config  | in        | cfg_wr_en           | cfg_wr_data (5): radix
//
// Each digit comes from the divider (a load, then one quotient bit per cycle) and is stored;
// after an optional leading minus sign the digits are read back, most significant first,
// with a fetch and then a load of the output register for each character.
// One number is converted at a time; the next is taken once the last character is loaded.
// Reset is asynchronous, active low, and sets the radix to ten.
// A stall on the output holds the output register and the sequencer waits in place.
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [RADIX_W-1:0]           cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [CHAR_W-1:0]            character,
    output logic                         final_char
);

    localparam int unsigned ADDR_W  = $clog2(VALUE_BITS);
    localparam int unsigned COUNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_LOAD
    } state_t;

    state_t                state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  final_reg, final_next;

    logic [RADIX_W-1:0]    base_sat;
    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  neg_in;
    logic                  out_free;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;
    itra_div_stat_t        div_stat;

    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [DIGIT_W-1:0]    ram_rd_data;

    // Clamp the configured radix into the supported range
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            base_sat = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            base_sat = RADIX_MAX;
        end
        else
        begin
            base_sat = radix_reg;
        end
    end

    // Signed magnitude only in base ten; other bases read the raw pattern
    assign value_u   = value;
    assign neg_in    = (base_sat == RADIX_DECIMAL) && value_u[VALUE_BITS-1];
    assign magnitude = neg_in ? (~value_u + VALUE_BITS'(1)) : value_u;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Restart the divider on its own quotient until that reaches zero
    assign div_start    = (state_reg == ST_IDLE && in_valid) ||
                          (state_reg == ST_DIV && div_stat.done && div_quotient != '0);
    assign div_dividend = (state_reg == ST_IDLE) ? magnitude : div_quotient;

    assign ram_wr_en = (state_reg == ST_DIV) && div_stat.done;
    assign ram_rd_en = (state_reg == ST_FETCH);

    itra_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (base_reg),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .stat      (div_stat)
    );

    // Digits, least significant first
    itra_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_BITS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (div_remainder),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Sequencer and output register next values
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = cfg_wr_en ? cfg_wr_data : radix_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        final_next     = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next  = base_sat;
                    neg_next   = neg_in;
                    count_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    count_next = count_reg + COUNT_W'(1);
                    if (div_quotient == '0)
                    begin
                        idx_next   = count_reg[ADDR_W-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_FETCH;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    final_next     = 1'b0;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(ram_rd_data);
                    final_next     = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_DECIMAL;
            base_reg      <= RADIX_DECIMAL;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            base_reg      <= base_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            final_reg     <= final_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign final_char = final_reg;

endmodule

// ===== hdl/itra_chk.sv =====
// Port-level checker for integer_to_radix_ascii, bound to the top level.
// Depends on itra_pkg and integer_to_radix_ascii.
module itra_chk
    import itra_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_wr_en,
    input logic [RADIX_W-1:0]           cfg_wr_data,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic signed [VALUE_BITS-1:0] value,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [CHAR_W-1:0]            character,
    input logic                         final_char
);

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(final_char))
        else $error("stalled output changed");

    // One number at a time: the input closes right after a transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open while converting");

    // A minus sign always has digits after it
    a_sign_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && character == CHAR_MINUS |-> !final_char)
        else $error("minus sign flagged final");

endmodule

bind integer_to_radix_ascii itra_chk #(.VALUE_BITS(VALUE_BITS)) u_itra_chk (.*);

// ===== tb/tb_integer_to_radix_ascii.sv =====
// Self-checking testbench for integer_to_radix_ascii: predicts the ASCII text of each
// accepted number in the current base and compares every output transfer in order.
// Depends on itra_pkg and the integer_to_radix_ascii RTL.
`timescale 1ns / 100ps

module tb_integer_to_radix_ascii;
    import itra_pkg::*;

    localparam int unsigned VBITS         = 32;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned END_CYCLES    = 1200;
    localparam int unsigned WATCHDOG_MAX  = 6000;
    localparam int unsigned PHASE_ITEMS   = 36;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              final_char;
    } text_char_t;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [RADIX_W-1:0]      cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic signed [VBITS-1:0] value       = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [CHAR_W-1:0]       character;
    logic                    final_char;

    logic [VBITS-1:0]   pending_values[$];
    text_char_t         expected_text[$];
    logic [RADIX_W-1:0] radix_setting = RADIX_DECIMAL;
    bit                 idling_on     = 1'b1;
    bit                 in_fire       = 1'b0;
    int unsigned        send_gap      = 0;
    int unsigned        stall_left    = 0;
    int unsigned        values_queued = 0;
    int unsigned        values_taken  = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles  = 0;

    integer_to_radix_ascii #(
        .VALUE_BITS (VBITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .final_char  (final_char)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Mostly short gaps, a few long ones; none while idling is off
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling_on)
        begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Clamp the programmed radix into the supported 2..16 range
    function automatic logic [RADIX_W-1:0] effective_base();
        if (radix_setting < RADIX_MIN)
        begin
            return RADIX_MIN;
        end
        if (radix_setting > RADIX_MAX)
        begin
            return RADIX_MAX;
        end
        return radix_setting;
    endfunction

    // Work out the characters of one number and queue them as expected transfers
    task automatic predict_text(input logic [VBITS-1:0] num);
        logic [RADIX_W-1:0] base;
        logic [VBITS-1:0]   mag;
        logic [3:0]         digits[VBITS];
        int                 count;
        int                 k;
        text_char_t         item;
        base  = effective_base();
        mag   = num;
        count = 0;
        if (base == RADIX_DECIMAL && num[VBITS-1])
        begin
            mag = -num;
            item.character  = CHAR_MINUS;
            item.final_char = 1'b0;
            expected_text.push_back(item);
        end
        do
        begin
            digits[count] = 4'(mag % base);
            count++;
            mag = mag / base;
        end
        while (mag != 0);
        for (k = count - 1; k >= 0; k--)
        begin
            if (digits[k] > 4'd9)
            begin
                item.character = CHAR_A_LOWER + CHAR_W'(digits[k] - 4'd10);
            end
            else
            begin
                item.character = CHAR_ZERO + CHAR_W'(digits[k]);
            end
            item.final_char = (k == 0);
            expected_text.push_back(item);
        end
    endtask

    // Compare one output transfer against the oldest expected character
    task automatic check_char(input logic [CHAR_W-1:0] got_char, input logic got_last);
        text_char_t want;
        if (expected_text.size() == 0)
        begin
            if (mismatch_count < REPORT_MAX)
            begin
                $display("%0t: unexpected character %h final %b", $realtime, got_char,
                         got_last);
            end
            mismatch_count++;
        end
        else
        begin
            want = expected_text.pop_front();
            if (want.character !== got_char || want.final_char !== got_last)
            begin
                if (mismatch_count < REPORT_MAX)
                begin
                    $display("%0t: character exp %h got %h, final exp %b got %b",
                             $realtime, want.character, got_char, want.final_char,
                             got_last);
                end
                mismatch_count++;
            end
        end
    endtask

    // Monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_text(value);
                values_taken++;
            end
            if (out_valid && !out_stall)
            begin
                check_char(character, final_char);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Driver: hold the payload while stalled, otherwise advance to the next number
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_values.size() != 0)
            begin
                in_valid <= 1'b1;
                value    <= pending_values.pop_front();
                send_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall the output in random bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_MAX);
        $display("Verification failed");
        $finish;
    end

    task automatic queue_value(input logic [VBITS-1:0] num);
        pending_values.push_back(num);
        values_queued++;
    endtask

    // Wait until every number is taken and every character has come out
    task automatic wait_idle(input int unsigned extra);
        while (values_taken != values_queued || expected_text.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_idle(DRAIN_CYCLES);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= r;
        radix_setting = r;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Near a power of the current base: exercises digit count boundaries
    function automatic logic [VBITS-1:0] radix_power_value();
        logic [63:0] p;
        int          steps;
        int          k;
        p     = 64'd1;
        steps = $urandom_range(VBITS - 1);
        for (k = 0; k < steps; k++)
        begin
            if (p * effective_base() <= 64'hFFFF_FFFF)
            begin
                p = p * effective_base();
            end
        end
        return p[VBITS-1:0] + VBITS'($urandom_range(2)) - 1;
    endfunction

    function automatic logic [VBITS-1:0] random_value();
        logic [VBITS-1:0] r;
        case ($urandom_range(9))
            4:       r = VBITS'($urandom_range(40));
            5:       r = -VBITS'($urandom_range(40));
            6:       r = radix_power_value();
            7:       r = $urandom_range(1) ? 32'h8000_0000 + VBITS'($urandom_range(3))
                                          : 32'h7FFF_FFFF - VBITS'($urandom_range(3));
            8:       r = $urandom() >> $urandom_range(VBITS - 1);
            9:       r = -($urandom() >> $urandom_range(VBITS - 1));
            default: r = $urandom();
        endcase
        return r;
    endfunction

    initial
    begin
        logic [RADIX_W-1:0] phase_radix[12];
        int                 p;
        int                 n;
        phase_radix = '{5'd10, 5'd16, 5'd2, 5'd31, 5'd0, 5'd8,
                        5'd10, 5'd17, 5'd1, 5'd3, 5'd16, 5'd10};

        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default base ten: sign handling, zero, extremes
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(-32'sd1);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(-32'sd10);
        queue_value(32'd123456789);

        // Base two: longest outputs, negatives read as unsigned
        write_radix(5'd2);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'd0);
        queue_value(32'd5);

        // Base sixteen: all letter digits
        write_radix(RADIX_MAX);
        queue_value(32'hABCD_EF01);
        queue_value(32'hDEAD_BEEF);
        queue_value(32'h7654_3210);
        queue_value(32'd0);

        // Out-of-range radix values saturate
        write_radix(5'd0);
        queue_value(32'd6);
        write_radix(5'd1);
        queue_value(-32'sd3);
        write_radix(5'd17);
        queue_value(32'd255);
        write_radix(5'd31);
        queue_value(32'h0000_1234);
        queue_value(-32'sd1);

        // Random phases, some with no idling at all
        for (p = 0; p < 12; p++)
        begin
            if (p == 5 || p == 9)
            begin
                write_radix(RADIX_W'($urandom_range(31)));
            end
            else
            begin
                write_radix(phase_radix[p]);
            end
            idling_on = (p % 4 != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                queue_value(random_value());
            end
        end

        wait_idle(END_CYCLES);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/itra_pkg.sv
hdl/itra_ram.sv
hdl/itra_div.sv
hdl/integer_to_radix_ascii.sv
hdl/itra_chk.sv
tb/tb_integer_to_radix_ascii.sv
